[sv/tid_pkg.sv]
// types, constants and helpers shared by the integer term decoder
package tid_pkg;

   localparam logic [7:0] TAG_SMALL_INT = 8'd97;
   localparam logic [7:0] TAG_INT       = 8'd98;
   localparam logic [7:0] TAG_SMALL_BIG = 8'd110;
   localparam logic [7:0] TAG_LARGE_BIG = 8'd111;

   localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

   localparam int DATA_W     = 8;
   localparam int VALUE_W    = 32;
   localparam int CONSUMED_W = 33;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SMALL,
      PH_HEADER,
      PH_SIGN,
      PH_DIGITS
   } phase_type;

   typedef enum logic [1:0] {
      FORM_SMALL,
      FORM_INT,
      FORM_SBIG,
      FORM_LBIG
   } form_type;

   typedef struct packed {
      phase_type               phase;
      form_type                form;
      logic [1:0]              header_count;
      logic [31:0]             accumulator;
      logic [31:0]             digits_left;
      logic [2:0]              digit_position;
      logic                    negative;
      logic [CONSUMED_W-1:0]   byte_count;
   } state_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      error;
      logic [CONSUMED_W-1:0]     consumed;
   } result_type;

   function automatic result_type error_result();
      result_type r;
      r.value    = '0;
      r.error    = 1'b1;
      r.consumed = '0;
      return r;
   endfunction

   function automatic result_type ok_result(input logic [31:0] v,
                                            input logic [CONSUMED_W-1:0] cnt);
      result_type r;
      r.value    = v;
      r.error    = 1'b0;
      r.consumed = cnt;
      return r;
   endfunction

   // range check and sign apply for a finished bignum
   function automatic result_type finish_big(input logic [31:0] acc,
                                             input logic neg,
                                             input logic [CONSUMED_W-1:0] cnt);
      result_type r;
      if (neg) begin
         if (acc > NEG_LIMIT) r = error_result();
         else r = ok_result(32'd0 - acc, cnt);
      end else begin
         if (acc > POS_LIMIT) r = error_result();
         else r = ok_result(acc, cnt);
      end
      return r;
   endfunction

endpackage

[sv/tid_step.sv]
// next-state and result logic for one byte of the term
module tid_step (
   input  tid_pkg::state_type  cur,
   input  logic [7:0]          data_byte,
   input  logic                restart,
   output tid_pkg::state_type  nxt,
   output logic                emit,
   output tid_pkg::result_type res
);

   logic [31:0] acc_shift;
   logic [31:0] acc_digit;
   logic [31:0] digits_dec;
   logic [tid_pkg::CONSUMED_W-1:0] cnt_inc;

   assign acc_shift  = {cur.accumulator[23:0], data_byte};
   assign acc_digit  = cur.accumulator
                       | ({24'd0, data_byte} << {cur.digit_position[1:0], 3'b000});
   assign digits_dec = cur.digits_left - 32'd1;
   assign cnt_inc    = cur.byte_count + tid_pkg::CONSUMED_W'(1);

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      res  = tid_pkg::error_result();
      if (restart || cur.phase == tid_pkg::PH_IDLE) begin
         nxt.byte_count     = tid_pkg::CONSUMED_W'(1);
         nxt.accumulator    = '0;
         nxt.digits_left    = '0;
         nxt.digit_position = '0;
         nxt.negative       = 1'b0;
         nxt.header_count   = '0;
         case (data_byte)
            tid_pkg::TAG_SMALL_INT: begin
               nxt.form  = tid_pkg::FORM_SMALL;
               nxt.phase = tid_pkg::PH_SMALL;
            end
            tid_pkg::TAG_INT: begin
               nxt.form         = tid_pkg::FORM_INT;
               nxt.phase        = tid_pkg::PH_HEADER;
               nxt.header_count = 2'd3;
            end
            tid_pkg::TAG_SMALL_BIG: begin
               nxt.form  = tid_pkg::FORM_SBIG;
               nxt.phase = tid_pkg::PH_HEADER;
            end
            tid_pkg::TAG_LARGE_BIG: begin
               nxt.form         = tid_pkg::FORM_LBIG;
               nxt.phase        = tid_pkg::PH_HEADER;
               nxt.header_count = 2'd3;
            end
            default: begin
               emit      = 1'b1;
               nxt.phase = tid_pkg::PH_IDLE;
            end
         endcase
      end else begin
         nxt.byte_count = cnt_inc;
         case (cur.phase)
            tid_pkg::PH_SMALL: begin
               emit = 1'b1;
               res  = tid_pkg::ok_result({24'd0, data_byte}, cnt_inc);
            end
            tid_pkg::PH_HEADER: begin
               nxt.accumulator = acc_shift;
               if (cur.header_count != 2'd0) begin
                  nxt.header_count = cur.header_count - 2'd1;
               end else if (cur.form == tid_pkg::FORM_INT) begin
                  emit = 1'b1;
                  res  = tid_pkg::ok_result(acc_shift, cnt_inc);
               end else begin
                  nxt.digits_left = acc_shift;
                  nxt.accumulator = '0;
                  nxt.phase       = tid_pkg::PH_SIGN;
               end
            end
            tid_pkg::PH_SIGN: begin
               nxt.negative = (data_byte != 8'd0);
               if (cur.digits_left == 32'd0) begin
                  emit = 1'b1;
                  res  = tid_pkg::finish_big(cur.accumulator, data_byte != 8'd0, cnt_inc);
               end else begin
                  nxt.phase = tid_pkg::PH_DIGITS;
               end
            end
            tid_pkg::PH_DIGITS: begin
               // digits past the fourth only need checking for zero
               if (cur.digit_position[2] && data_byte != 8'd0) begin
                  emit = 1'b1;
               end else begin
                  if (!cur.digit_position[2]) begin
                     nxt.accumulator    = acc_digit;
                     nxt.digit_position = cur.digit_position + 3'd1;
                  end
                  nxt.digits_left = digits_dec;
                  if (digits_dec == 32'd0) begin
                     emit = 1'b1;
                     res  = tid_pkg::finish_big(nxt.accumulator, cur.negative, cnt_inc);
                  end
               end
            end
            default: begin
               nxt.phase = tid_pkg::PH_IDLE;
            end
         endcase
      end
      if (emit) nxt.phase = tid_pkg::PH_IDLE;
   end

endmodule

[sv/tid_out_reg.sv]
// result register on the master side of the decoder
module tid_out_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  tid_pkg::result_type                 res,
   output logic                                room,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tid_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser
);

   logic                valid_ff;
   logic                valid_in;
   tid_pkg::result_type res_ff;

   assign room     = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(tid_pkg::RSP_DATA_W - tid_pkg::CONSUMED_W - tid_pkg::VALUE_W){1'b0}},
                        res_ff.consumed, res_ff.value};
   assign rsp_tuser  = res_ff.error;

endmodule

[sv/term_integer_decoder_core.sv]
// Integer term decoder: takes one byte per transfer and returns one result per
// finished term or error. A byte is taken every cycle when the result side keeps
// up; a byte moves through the input register and the term state logic into the
// result register, which takes the result for the byte that ends the term.
// The only loop is the term state register, updated once per byte.
// req_tuser high abandons any term in progress and treats the byte as a tag.
module term_integer_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] value, [64:32] consumed, rest zero
   output logic        rsp_tuser    // [0] error
);

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_restart_ff;
   logic                out_room;
   logic                step_fire;
   logic                step_emit;
   tid_pkg::state_type  state_ff;
   tid_pkg::state_type  state_in;
   tid_pkg::result_type step_res;

   assign step_fire   = in_valid_ff && out_room;
   assign req_tready  = !in_valid_ff || out_room;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 :
                        (step_fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff    <= req_tdata;
         in_restart_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   tid_step u_step (
      .cur       (state_ff),
      .data_byte (in_byte_ff),
      .restart   (in_restart_ff),
      .nxt       (state_in),
      .emit      (step_emit),
      .res       (step_res)
   );

   tid_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step_fire && step_emit),
      .res        (step_res),
      .room       (out_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTH
   // an error result carries zero value and zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 72'd0)
      else $error("error result with nonzero payload");

   // a good term is at least a tag and one more byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[64:32] >= 33'd2)
      else $error("good result with too small byte count");

   // every result leaves the decoder waiting for a tag
   assert property (@(posedge clock) disable iff (reset)
      step_fire && step_emit |=> state_ff.phase == tid_pkg::PH_IDLE)
      else $error("decoder not idle after a result");
`endif

endmodule

[verif/tb_top.sv]
// self-checking testbench for the integer term decoder core
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 280;
   localparam int QUIET_TAIL   = 60;

   typedef struct packed {
      logic [7:0] data;
      logic       restart;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // [31:0] value, [64:32] consumed, rest zero
   logic        rsp_tuser;           // [0] error

   term_integer_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   byte_item_type       pending_bytes[$];
   tid_pkg::result_type decoded_terms[$];
   byte_item_type       next_item;
   tid_pkg::result_type want;
   int         cycle_count = 0;
   int         fail_count = 0;
   int         bytes_sent = 0;
   int         terms_seen = 0;
   int         errors_seen = 0;
   int         send_gap = 0;
   int         take_gap = 0;
   int         bytes_queued = 0;
   logic       force_restart = 1'b0;

   // decoder state as the predictor sees it
   tid_pkg::phase_type dec_phase = tid_pkg::PH_IDLE;
   tid_pkg::form_type  dec_form = tid_pkg::FORM_SMALL;
   logic [1:0]  hdr_left = '0;
   logic [31:0] acc = '0;
   logic [31:0] digits_left = '0;
   logic [2:0]  digit_pos = '0;
   logic        neg = 1'b0;
   logic [32:0] nbytes = '0;

   task automatic record_term(input logic [31:0] v, input logic err, input logic [32:0] cnt);
      tid_pkg::result_type r;
      r.value    = err ? 32'd0 : v;
      r.error    = err;
      r.consumed = err ? 33'd0 : cnt;
      decoded_terms.push_back(r);
      dec_phase = tid_pkg::PH_IDLE;
   endtask

   task automatic close_bignum();
      if (neg) begin
         if (acc > tid_pkg::NEG_LIMIT) record_term(32'd0, 1'b1, 33'd0);
         else record_term(32'd0 - acc, 1'b0, nbytes);
      end else begin
         if (acc > tid_pkg::POS_LIMIT) record_term(32'd0, 1'b1, 33'd0);
         else record_term(acc, 1'b0, nbytes);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic rs);
      if (rs || dec_phase == tid_pkg::PH_IDLE) begin
         nbytes      = 33'd1;
         acc         = '0;
         digits_left = '0;
         digit_pos   = '0;
         neg         = 1'b0;
         hdr_left    = '0;
         case (b)
            tid_pkg::TAG_SMALL_INT: begin
               dec_form  = tid_pkg::FORM_SMALL;
               dec_phase = tid_pkg::PH_SMALL;
            end
            tid_pkg::TAG_INT: begin
               dec_form  = tid_pkg::FORM_INT;
               dec_phase = tid_pkg::PH_HEADER;
               hdr_left  = 2'd3;
            end
            tid_pkg::TAG_SMALL_BIG: begin
               dec_form  = tid_pkg::FORM_SBIG;
               dec_phase = tid_pkg::PH_HEADER;
            end
            tid_pkg::TAG_LARGE_BIG: begin
               dec_form  = tid_pkg::FORM_LBIG;
               dec_phase = tid_pkg::PH_HEADER;
               hdr_left  = 2'd3;
            end
            default: record_term(32'd0, 1'b1, 33'd0);
         endcase
      end else begin
         nbytes = nbytes + 33'd1;
         case (dec_phase)
            tid_pkg::PH_SMALL: record_term({24'd0, b}, 1'b0, nbytes);
            tid_pkg::PH_HEADER: begin
               acc = {acc[23:0], b};
               if (hdr_left != 2'd0) begin
                  hdr_left = hdr_left - 2'd1;
               end else if (dec_form == tid_pkg::FORM_INT) begin
                  record_term(acc, 1'b0, nbytes);
               end else begin
                  digits_left = acc;
                  acc         = '0;
                  dec_phase   = tid_pkg::PH_SIGN;
               end
            end
            tid_pkg::PH_SIGN: begin
               neg = (b != 8'd0);
               if (digits_left == 32'd0) close_bignum();
               else dec_phase = tid_pkg::PH_DIGITS;
            end
            default: begin
               // digits past the fourth must be zero
               if (digit_pos >= 3'd4 && b != 8'd0) begin
                  record_term(32'd0, 1'b1, 33'd0);
               end else begin
                  if (digit_pos < 3'd4) begin
                     acc       = acc | (32'(b) << (8 * digit_pos));
                     digit_pos = digit_pos + 3'd1;
                  end
                  digits_left = digits_left - 32'd1;
                  if (digits_left == 32'd0) close_bignum();
               end
            end
         endcase
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic rs);
      byte_item_type it;
      it.data    = b;
      it.restart = rs;
      pending_bytes.push_back(it);
      bytes_queued++;
   endtask

   task automatic send_small(input logic [7:0] v, input logic rs);
      push_byte(tid_pkg::TAG_SMALL_INT, rs);
      push_byte(v, 1'b0);
   endtask

   task automatic send_int(input logic [31:0] v, input logic rs);
      push_byte(tid_pkg::TAG_INT, rs);
      for (int i = 3; i >= 0; i--) push_byte(v[8*i +: 8], 1'b0);
   endtask

   // bad_pos at 4 or above puts bad_byte there and ends the term early
   task automatic send_bignum(input logic is_large, input logic [31:0] count,
                              input logic [7:0] sign, input logic [31:0] mag,
                              input int unsigned bad_pos, input logic [7:0] bad_byte,
                              input logic rs);
      push_byte(is_large ? tid_pkg::TAG_LARGE_BIG : tid_pkg::TAG_SMALL_BIG, rs);
      if (is_large) begin
         for (int i = 3; i >= 0; i--) push_byte(count[8*i +: 8], 1'b0);
      end else begin
         push_byte(count[7:0], 1'b0);
      end
      push_byte(sign, 1'b0);
      for (int unsigned i = 0; i < (is_large ? count : {24'd0, count[7:0]}); i++) begin
         if (i < 4) begin
            push_byte(mag[8*i +: 8], 1'b0);
         end else if (bad_pos >= 4 && i == bad_pos) begin
            push_byte(bad_byte, 1'b0);
            break;
         end else begin
            push_byte(8'd0, 1'b0);
         end
      end
   endtask

   function automatic logic [31:0] pick_magnitude();
      case ($urandom_range(0, 6))
         0: return 32'd0;
         1: return tid_pkg::POS_LIMIT;
         2: return tid_pkg::NEG_LIMIT;
         3: return 32'h8000_0001;
         4: return 32'hFFFF_FFFF;
         5: return 32'($urandom_range(0, 255));
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random_term();
      logic        rs;
      logic [7:0]  b;
      logic [7:0]  sign;
      logic [31:0] count;
      int unsigned bad;
      rs = force_restart || ($urandom_range(0, 3) == 0);
      force_restart = 1'b0;
      case ($urandom_range(0, 11))
         0, 1: send_small(8'($urandom_range(0, 255)), rs);
         2, 3: send_int(pick_magnitude(), rs);
         4, 5, 6, 7, 8: begin
            case ($urandom_range(0, 2))
               0: sign = 8'd0;
               1: sign = 8'd1;
               default: sign = 8'($urandom_range(0, 255));
            endcase
            bad = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : 0;
            if ($urandom_range(0, 2) == 0) begin
               // long count over the wide header; a nonzero high digit ends it
               if ($urandom_range(0, 1) == 0) begin
                  count = $urandom() | 32'h10;
                  bad   = $urandom_range(4, 7);
               end else begin
                  count = 32'($urandom_range(0, 7));
               end
               send_bignum(1'b1, count, sign, pick_magnitude(), bad,
                           8'($urandom_range(1, 255)), rs);
            end else begin
               send_bignum(1'b0, 32'($urandom_range(0, 7)), sign, pick_magnitude(), bad,
                           8'($urandom_range(1, 255)), rs);
            end
         end
         9: begin
            b = 8'($urandom_range(0, 255));
            if (b == tid_pkg::TAG_SMALL_INT || b == tid_pkg::TAG_INT ||
                b == tid_pkg::TAG_SMALL_BIG || b == tid_pkg::TAG_LARGE_BIG)
               b = b ^ 8'h40;
            push_byte(b, rs);
         end
         default: begin
            // partial term, noise bytes, then a restart
            case ($urandom_range(0, 3))
               0: push_byte(tid_pkg::TAG_SMALL_INT, rs);
               1: push_byte(tid_pkg::TAG_INT, rs);
               2: push_byte(tid_pkg::TAG_SMALL_BIG, rs);
               default: push_byte(tid_pkg::TAG_LARGE_BIG, rs);
            endcase
            repeat ($urandom_range(0, 3))
               push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
            force_restart = 1'b1;
         end
      endcase
   endtask

   // input side
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            decode_byte(req_tdata, req_tuser);
            bytes_sent++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            next_item = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.data;
            req_tuser  <= next_item.restart;
            if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 11) == 0)
               send_gap = $urandom_range(1, 19);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            terms_seen++;
            if (rsp_tuser) errors_seen++;
            if (decoded_terms.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected transfer: value %h error %b consumed %h",
                           rsp_tdata[31:0], rsp_tuser, rsp_tdata[64:32]);
            end else begin
               want = decoded_terms.pop_front();
               if (rsp_tdata[31:0] !== want.value || rsp_tuser !== want.error ||
                   rsp_tdata[64:32] !== want.consumed) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("term %0d: expected value %h error %b consumed %h, got %h %b %h",
                              terms_seen, want.value, want.error, want.consumed,
                              rsp_tdata[31:0], rsp_tuser, rsp_tdata[64:32]);
               end
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
               take_gap = $urandom_range(1, 19);
         end
      end
   end

   initial begin
      // directed terms
      send_small(8'd0, 1'b0);
      send_small(8'hFF, 1'b0);
      send_int(32'h7FFF_FFFF, 1'b0);
      send_int(32'h8000_0000, 1'b0);
      send_int(32'hFFFF_FFFF, 1'b0);
      send_int(32'd0, 1'b1);
      send_bignum(1'b0, 32'd0, 8'd0, 32'd0, 0, 8'd0, 1'b0);
      send_bignum(1'b0, 32'd0, 8'hFF, 32'd0, 0, 8'd0, 1'b0);
      send_bignum(1'b0, 32'd4, 8'd1, tid_pkg::NEG_LIMIT, 0, 8'd0, 1'b0);
      send_bignum(1'b0, 32'd4, 8'd0, tid_pkg::NEG_LIMIT, 0, 8'd0, 1'b0);
      send_bignum(1'b0, 32'd4, 8'd1, 32'h8000_0001, 0, 8'd0, 1'b0);
      send_bignum(1'b0, 32'd4, 8'd0, tid_pkg::POS_LIMIT, 0, 8'd0, 1'b0);
      send_bignum(1'b0, 32'd6, 8'd0, 32'h1234_5678, 0, 8'd0, 1'b0);
      send_bignum(1'b0, 32'd255, 8'd0, 32'hA5A5_5A5A, 4, 8'hFF, 1'b0);
      send_bignum(1'b0, 32'd3, 8'd1, 32'd0, 0, 8'd0, 1'b0);
      send_bignum(1'b1, 32'd2, 8'd0, 32'h0000_BEEF, 0, 8'd0, 1'b0);
      send_bignum(1'b1, 32'hFFFF_FFFF, 8'd1, 32'h0403_0201, 4, 8'h80, 1'b0);
      send_bignum(1'b1, 32'd0, 8'd0, 32'd0, 0, 8'd0, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'd99, 1'b1);
      // restart in the middle of a term
      push_byte(tid_pkg::TAG_INT, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      send_small(8'h55, 1'b1);
      push_byte(tid_pkg::TAG_SMALL_BIG, 1'b0);
      push_byte(8'h10, 1'b1);

      bytes_queued = 0;
      while (bytes_queued < RANDOM_BYTES) send_random_term();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while ((pending_bytes.size() != 0 || req_tvalid || decoded_terms.size() != 0) &&
             cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout: %0d results still awaited", decoded_terms.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         repeat (8) @(posedge clock);
         $display("%0d bytes decoded into %0d results, %0d of them error results",
                  bytes_sent, terms_seen, errors_seen);
         $display("%0d mismatches", fail_count);
         if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
         end else begin
            $display("SCOREBOARD MISMATCH");
         end
         $finish;
      end
   end

endmodule
